// ----- sv/shs_pkg.sv -----
`timescale 1ns / 1ps
// shs_pkg: types, constants and register indexes of the staged heater sequencer
// no dependencies; imported by every module of the block

package shs_pkg;

    localparam int TIMER_BITS_DEF = 8;
    localparam int TEMP_W         = 12;
    localparam int THR_W          = 11;
    localparam int SEC_W          = 8;
    localparam int STAGE_W        = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = THR_W;

    // fixed durations, seconds
    localparam logic [SEC_W-1:0] STEP_PULSE_SECS = 8'd2;
    localparam logic [SEC_W-1:0] STEP_PAUSE_SECS = 8'd6;
    localparam logic [SEC_W-1:0] PUMP_PULSE_SECS = 8'd3;
    localparam logic [SEC_W-1:0] PUMP_PAUSE_SECS = 8'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ECO_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_HEAT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WAIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_HEAT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_WAIT = 3'd7;

    // program stages
    localparam logic [STAGE_W-1:0] ST_CHECK       = 5'd0;
    localparam logic [STAGE_W-1:0] ST_INIT_START  = 5'd1;
    localparam logic [STAGE_W-1:0] ST_INIT_HEAT   = 5'd2;
    localparam logic [STAGE_W-1:0] ST_INIT_OFF    = 5'd3;
    localparam logic [STAGE_W-1:0] ST_INIT_WAIT   = 5'd4;
    localparam logic [STAGE_W-1:0] ST_STEP_ENTRY  = 5'd5;
    localparam logic [STAGE_W-1:0] ST_STEP_CHECK  = 5'd6;
    localparam logic [STAGE_W-1:0] ST_STEP_START  = 5'd7;
    localparam logic [STAGE_W-1:0] ST_STEP_HEAT   = 5'd8;
    localparam logic [STAGE_W-1:0] ST_STEP_OFF    = 5'd9;
    localparam logic [STAGE_W-1:0] ST_STEP_WAIT   = 5'd10;
    localparam logic [STAGE_W-1:0] ST_HOLD_ENTRY  = 5'd11;
    localparam logic [STAGE_W-1:0] ST_HOLD_READY  = 5'd12;
    localparam logic [STAGE_W-1:0] ST_HOLD_CLEAR  = 5'd13;
    localparam logic [STAGE_W-1:0] ST_HOLD_CHECK  = 5'd14;
    localparam logic [STAGE_W-1:0] ST_HOLD_START  = 5'd15;
    localparam logic [STAGE_W-1:0] ST_HOLD_HEAT   = 5'd16;
    localparam logic [STAGE_W-1:0] ST_HOLD_OFF    = 5'd17;
    localparam logic [STAGE_W-1:0] ST_HOLD_WAIT   = 5'd18;
    localparam logic [STAGE_W-1:0] ST_PUMP_START  = 5'd19;
    localparam logic [STAGE_W-1:0] ST_PUMP_HEAT   = 5'd20;
    localparam logic [STAGE_W-1:0] ST_PUMP_OFF    = 5'd21;
    localparam logic [STAGE_W-1:0] ST_PUMP_WAIT   = 5'd22;
    localparam logic [STAGE_W-1:0] ST_END         = 5'd23;
    localparam logic [STAGE_W-1:0] ST_ECO_CHECK   = 5'd24;
    localparam logic [STAGE_W-1:0] ST_ECO_START   = 5'd25;
    localparam logic [STAGE_W-1:0] ST_ECO_HEAT    = 5'd26;
    localparam logic [STAGE_W-1:0] ST_ECO_OFF     = 5'd27;
    localparam logic [STAGE_W-1:0] ST_ECO_WAIT    = 5'd28;

    typedef struct packed {
        logic [THR_W-1:0] init_threshold;
        logic [THR_W-1:0] step_threshold;
        logic [THR_W-1:0] hold_threshold;
        logic [THR_W-1:0] eco_threshold;
        logic [SEC_W-1:0] init_heat_seconds;
        logic [SEC_W-1:0] init_wait_seconds;
        logic [SEC_W-1:0] hold_heat_seconds;
        logic [SEC_W-1:0] hold_wait_seconds;
    } t_cfg;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     second_strobe;
        logic                     pump_running;
        logic                     hold_enable;
        logic                     eco_enable;
        logic                     stop_request;
    } t_req_item;

    typedef struct packed {
        logic                 heater_on;
        logic                 ready_flag;
        logic                 above_hold;
        logic [STAGE_W-1:0]   stage;
        logic                 halted;
    } t_rsp_item;

    typedef struct packed {
        logic [STAGE_W-1:0] stage;
        logic               heater;
        logic               ready;
        logic               halted;
    } t_seq_state;

endpackage

// ----- sv/shs_if.sv -----
`timescale 1ns / 1ps
// shs_req_if / shs_rsp_if: valid-ready channels for control ticks and results
// depends on shs_pkg for field widths

interface shs_req_if
    import shs_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;
    logic                     second_strobe;
    logic                     pump_running;
    logic                     hold_enable;
    logic                     eco_enable;
    logic                     stop_request;

    modport source (
        output valid, temperature, second_strobe, pump_running,
               hold_enable, eco_enable, stop_request,
        input  ready
    );
    modport sink (
        input  valid, temperature, second_strobe, pump_running,
               hold_enable, eco_enable, stop_request,
        output ready
    );
endinterface

interface shs_rsp_if
    import shs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               heater_on;
    logic               ready_flag;
    logic               above_hold;
    logic [STAGE_W-1:0] stage;
    logic               halted;

    modport source (
        output valid, heater_on, ready_flag, above_hold, stage, halted,
        input  ready
    );
    modport sink (
        input  valid, heater_on, ready_flag, above_hold, stage, halted,
        output ready
    );
endinterface

// ----- sv/staged_heater_sequencer_core.sv -----
`timescale 1ns / 1ps
// staged_heater_sequencer_core: top level of the boiler heater stage program
// depends on shs_pkg, shs_if, shs_cfg_regs and shs_step
//
//  channel   dir  handshake      content
//  i_req     in   valid/ready    one control tick: temperature and flags
//  o_rsp     out  valid/ready    heater, ready, above_hold, stage, halted
//  i_cfg_*   in   write enable   threshold and duration registers
//
// one request per cycle while results are taken; each result passes the input
// register, then the result register, and is set by the single step unit
// the sequence state advances as a request leaves the input register
// synchronous active-low reset: stage 0, timer 0, heater, ready and halt clear
// a stalled result holds its register; the input register keeps filling
// until it too is full, then i_req.ready drops

module staged_heater_sequencer_core
    import shs_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    shs_req_if.sink               i_req,
    shs_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                  cfg;
    logic                  r_s1_valid;
    t_req_item             r_s1_item;
    logic                  r_o_valid;
    t_rsp_item             r_o_item;
    t_seq_state            r_state;
    logic [TIMER_BITS-1:0] r_timer;
    t_seq_state            n_state;
    logic [TIMER_BITS-1:0] n_timer;
    t_rsp_item             n_o_item;
    t_req_item             req_item;
    logic                  out_free;
    logic                  s1_adv;
    logic                  req_take;

    shs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    shs_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_cfg   (cfg),
        .i_item  (r_s1_item),
        .i_state (r_state),
        .i_timer (r_timer),
        .o_state (n_state),
        .o_timer (n_timer),
        .o_rsp   (n_o_item)
    );

    assign req_item.temperature   = i_req.temperature;
    assign req_item.second_strobe = i_req.second_strobe;
    assign req_item.pump_running  = i_req.pump_running;
    assign req_item.hold_enable   = i_req.hold_enable;
    assign req_item.eco_enable    = i_req.eco_enable;
    assign req_item.stop_request  = i_req.stop_request;

    assign out_free    = !r_o_valid || o_rsp.ready;
    assign s1_adv      = r_s1_valid && out_free;
    assign i_req.ready = !r_s1_valid || out_free;
    assign req_take    = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_state    <= '0;
            r_timer    <= '0;
        end else begin
            if (req_take) r_s1_valid <= 1'b1;
            else if (s1_adv) r_s1_valid <= 1'b0;
            if (s1_adv) begin
                r_o_valid <= 1'b1;
                r_state   <= n_state;
                r_timer   <= n_timer;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) r_s1_item <= req_item;
        if (s1_adv) r_o_item <= n_o_item;
    end

    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.heater_on  = r_o_item.heater_on;
    assign o_rsp.ready_flag = r_o_item.ready_flag;
    assign o_rsp.above_hold = r_o_item.above_hold;
    assign o_rsp.stage      = r_o_item.stage;
    assign o_rsp.halted     = r_o_item.halted;

endmodule

// ----- sv/shs_cfg_regs.sv -----
`timescale 1ns / 1ps
// shs_cfg_regs: threshold and duration register bank behind the write port
// depends on shs_pkg

module shs_cfg_regs
    import shs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INIT_THR:  n_cfg.init_threshold    = i_cfg_data;
                CFG_STEP_THR:  n_cfg.step_threshold    = i_cfg_data;
                CFG_HOLD_THR:  n_cfg.hold_threshold    = i_cfg_data;
                CFG_ECO_THR:   n_cfg.eco_threshold     = i_cfg_data;
                CFG_INIT_HEAT: n_cfg.init_heat_seconds = i_cfg_data[SEC_W-1:0];
                CFG_INIT_WAIT: n_cfg.init_wait_seconds = i_cfg_data[SEC_W-1:0];
                CFG_HOLD_HEAT: n_cfg.hold_heat_seconds = i_cfg_data[SEC_W-1:0];
                CFG_HOLD_WAIT: n_cfg.hold_wait_seconds = i_cfg_data[SEC_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_threshold    <= 11'd640;
            r_cfg.step_threshold    <= 11'd1280;
            r_cfg.hold_threshold    <= 11'd1408;
            r_cfg.eco_threshold     <= 11'd800;
            r_cfg.init_heat_seconds <= 8'd15;
            r_cfg.init_wait_seconds <= 8'd12;
            r_cfg.hold_heat_seconds <= 8'd1;
            r_cfg.hold_wait_seconds <= 8'd8;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/shs_step.sv -----
`timescale 1ns / 1ps
// shs_step: next stage, timer, heater, ready and halt logic for one control tick
// depends on shs_pkg

module shs_step
    import shs_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  t_cfg                  i_cfg,
    input  t_req_item             i_item,
    input  t_seq_state            i_state,
    input  logic [TIMER_BITS-1:0] i_timer,
    output t_seq_state            o_state,
    output logic [TIMER_BITS-1:0] o_timer,
    output t_rsp_item             o_rsp
);

    localparam int CMP_W = (TIMER_BITS > SEC_W) ? TIMER_BITS : SEC_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    logic [TIMER_BITS-1:0] tick_timer;
    logic [CMP_W-1:0]      e_cmp;
    logic                  halt_now;
    logic                  below_init;
    logic                  below_step;
    logic                  below_hold;
    logic                  below_eco;
    t_seq_state            adv;
    logic [TIMER_BITS-1:0] adv_timer;

    function automatic logic below_thr(logic signed [TEMP_W-1:0] t, logic [THR_W-1:0] thr);
        return t < $signed({1'b0, thr});
    endfunction

    function automatic logic past(logic [CMP_W-1:0] e, logic [SEC_W-1:0] dur);
        return e > CMP_W'(dur);
    endfunction

    assign halt_now   = i_state.halted | i_item.stop_request;
    assign tick_timer = (i_item.second_strobe && i_timer != TIMER_MAX) ?
                        i_timer + 1'b1 : i_timer;
    assign e_cmp      = CMP_W'(tick_timer);
    assign below_init = below_thr(i_item.temperature, i_cfg.init_threshold);
    assign below_step = below_thr(i_item.temperature, i_cfg.step_threshold);
    assign below_hold = below_thr(i_item.temperature, i_cfg.hold_threshold);
    assign below_eco  = below_thr(i_item.temperature, i_cfg.eco_threshold);

    always_comb begin
        adv        = i_state;
        adv_timer  = tick_timer;
        unique case (i_state.stage)
            ST_CHECK: begin
                adv_timer = '0;
                if (below_init) begin
                    adv.heater = 1'b1;
                    adv.stage  = ST_INIT_START;
                end else begin
                    adv.stage = ST_STEP_CHECK;
                end
            end
            ST_INIT_START: begin
                adv_timer = '0;
                adv.stage = ST_INIT_HEAT;
            end
            ST_INIT_HEAT: begin
                if (past(e_cmp, i_cfg.init_heat_seconds)) begin
                    adv.heater = 1'b0;
                    adv.stage  = ST_INIT_OFF;
                end
            end
            ST_INIT_OFF: begin
                adv_timer = '0;
                adv.stage = ST_INIT_WAIT;
            end
            ST_INIT_WAIT: begin
                if (past(e_cmp, i_cfg.init_wait_seconds)) adv.stage = ST_STEP_ENTRY;
            end
            ST_STEP_ENTRY: begin
                adv_timer = '0;
                adv.stage = ST_STEP_CHECK;
            end
            ST_STEP_CHECK: begin
                if (below_step) begin
                    adv.heater = 1'b1;
                    adv.stage  = ST_STEP_START;
                end else begin
                    adv.stage = ST_HOLD_ENTRY;
                end
            end
            ST_STEP_START: begin
                adv_timer = '0;
                adv.stage = ST_STEP_HEAT;
            end
            ST_STEP_HEAT: begin
                if (past(e_cmp, STEP_PULSE_SECS)) begin
                    adv.heater = 1'b0;
                    adv.stage  = ST_STEP_OFF;
                end
            end
            ST_STEP_OFF: begin
                adv_timer = '0;
                adv.stage = ST_STEP_WAIT;
            end
            ST_STEP_WAIT: begin
                if (past(e_cmp, STEP_PAUSE_SECS))
                    adv.stage = below_step ? ST_STEP_ENTRY : ST_HOLD_ENTRY;
            end
            ST_HOLD_ENTRY: begin
                adv_timer = '0;
                adv.stage = i_item.eco_enable ? ST_ECO_CHECK : ST_HOLD_READY;
            end
            ST_HOLD_READY: begin
                adv.ready = 1'b1;
                adv.stage = ST_HOLD_CLEAR;
            end
            ST_HOLD_CLEAR: begin
                adv_timer = '0;
                adv.stage = ST_HOLD_CHECK;
            end
            ST_HOLD_CHECK: begin
                if (!i_item.hold_enable) begin
                    adv.stage = ST_END;
                end else if (below_hold) begin
                    adv.heater = 1'b1;
                    adv.stage  = i_item.pump_running ? ST_PUMP_START : ST_HOLD_START;
                end
            end
            ST_HOLD_START: begin
                adv_timer = '0;
                adv.stage = ST_HOLD_HEAT;
            end
            ST_HOLD_HEAT: begin
                if (past(e_cmp, i_cfg.hold_heat_seconds)) begin
                    adv.heater = 1'b0;
                    adv.stage  = ST_HOLD_OFF;
                end
            end
            ST_HOLD_OFF: begin
                adv_timer = '0;
                adv.stage = ST_HOLD_WAIT;
            end
            ST_HOLD_WAIT: begin
                if (past(e_cmp, i_cfg.hold_wait_seconds) && below_hold)
                    adv.stage = ST_HOLD_ENTRY;
            end
            ST_PUMP_START: begin
                adv_timer = '0;
                adv.stage = ST_PUMP_HEAT;
            end
            ST_PUMP_HEAT: begin
                if (past(e_cmp, PUMP_PULSE_SECS)) begin
                    adv.heater = 1'b0;
                    adv.stage  = ST_PUMP_OFF;
                end
            end
            ST_PUMP_OFF: begin
                adv_timer = '0;
                adv.stage = ST_PUMP_WAIT;
            end
            ST_PUMP_WAIT: begin
                if (past(e_cmp, PUMP_PAUSE_SECS) && below_hold)
                    adv.stage = ST_STEP_ENTRY;
            end
            ST_END: begin
                adv.heater = 1'b0;
                adv.ready  = 1'b0;
                if (i_item.hold_enable) adv.stage = ST_CHECK;
            end
            ST_ECO_CHECK: begin
                if (!i_item.eco_enable) begin
                    adv.stage = ST_STEP_ENTRY;
                end else if (below_eco) begin
                    adv.heater = 1'b1;
                    adv.stage  = ST_ECO_START;
                end
            end
            ST_ECO_START: begin
                adv_timer = '0;
                adv.stage = ST_ECO_HEAT;
            end
            ST_ECO_HEAT: begin
                if (past(e_cmp, i_cfg.hold_heat_seconds)) begin
                    adv.heater = 1'b0;
                    adv.stage  = ST_ECO_OFF;
                end
            end
            ST_ECO_OFF: begin
                adv_timer = '0;
                adv.stage = ST_ECO_WAIT;
            end
            ST_ECO_WAIT: begin
                if (past(e_cmp, i_cfg.hold_wait_seconds)) adv.stage = ST_ECO_CHECK;
            end
            // unreachable codes fall back to the start
            default: adv.stage = ST_CHECK;
        endcase
    end

    always_comb begin
        if (halt_now) begin
            o_state        = i_state;
            o_state.halted = 1'b1;
            o_timer        = i_timer;
        end else begin
            o_state        = adv;
            o_state.halted = 1'b0;
            o_timer        = adv_timer;
        end
    end

    assign o_rsp.heater_on  = o_state.heater;
    assign o_rsp.ready_flag = o_state.ready;
    assign o_rsp.above_hold = i_item.temperature > $signed({1'b0, i_cfg.hold_threshold});
    assign o_rsp.stage      = o_state.stage;
    assign o_rsp.halted     = o_state.halted;

endmodule
